// ----- hdl/dht_pkg.sv -----
// Shared types and constants for the double-hashed key/value table.
package dht_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int SIZE_W  = 11;
  localparam int KEY_W   = 34;
  localparam int VAL_W   = 32;
  localparam int WORD_W  = 1 + KEY_W + VAL_W;
  localparam int CNT_W   = $clog2(KEY_W + 1);

  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(DEPTH);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] phone_key;
    logic [VAL_W-1:0] caller_value;
  } in_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] slot;
    logic [VAL_W-1:0]  found_value;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [KEY_W-1:0]  quotient;
    logic [SIZE_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ----- hdl/dht_ram.sv -----
// Generic single-port RAM with registered read.
module dht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hdl/dht_div.sv -----
// Restoring divider, one quotient bit per cycle.
module dht_div (
  input  logic              clk,
  input  logic              rst,
  input  dht_pkg::div_req_t req,
  output dht_pkg::div_rsp_t rsp
);

  logic                            busy;
  logic                            done;
  logic [dht_pkg::CNT_W-1:0]       cnt;
  logic [dht_pkg::KEY_W-1:0]       quo;
  logic [dht_pkg::SIZE_W-1:0]      rem;
  logic [dht_pkg::SIZE_W-1:0]      dsr;
  logic [dht_pkg::SIZE_W:0]        trial;
  logic                            ge;
  logic [dht_pkg::SIZE_W-1:0]      rem_next;

  always_comb begin
    trial    = {rem, quo[dht_pkg::KEY_W-1]};
    ge       = trial >= {1'b0, dsr};
    rem_next = ge ? dht_pkg::SIZE_W'(trial - {1'b0, dsr})
                  : trial[dht_pkg::SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[dht_pkg::KEY_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == dht_pkg::CNT_W'(dht_pkg::KEY_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{busy: busy, done: done, quotient: quo, remainder: rem};

endmodule

// ----- hdl/double_hash_table.sv -----
// Top level: sequencer for the double-hashed key/value table.
//
// One operation at a time. Search and delete walk slots 0..n-1 (n the
// effective size) one slot after another, stopping at the first hit. Insert
// first makes the same walk to rule out a duplicate, then runs the shared
// 34-step divider twice (key mod n gives the home slot, the quotient mod n
// made odd gives the stride) and probes from the home slot by the stride
// until it finds a free slot or has tried n slots. After reset and after
// every table_size write the table memory is swept clear, one slot a cycle
// over all 1024 slots, during which no input beat is taken.
// A result beat must be taken before the next input beat is accepted.
module double_hash_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dht_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dht_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [dht_pkg::SIZE_W-1:0]  cfg_wdata
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CK  = 4'd3;
  localparam logic [3:0] S_DIV1     = 4'd4;
  localparam logic [3:0] S_DIV1_W   = 4'd5;
  localparam logic [3:0] S_DIV2     = 4'd6;
  localparam logic [3:0] S_DIV2_W   = 4'd7;
  localparam logic [3:0] S_PROBE_RD = 4'd8;
  localparam logic [3:0] S_PROBE_CK = 4'd9;

  logic [3:0]                  state;
  logic [dht_pkg::SIZE_W-1:0]  n_size;
  logic [dht_pkg::SIZE_W-1:0]  entry_count;
  logic [dht_pkg::ADDR_W-1:0]  clr_addr;
  logic [dht_pkg::ADDR_W-1:0]  scan_idx;
  logic [dht_pkg::ADDR_W-1:0]  probe;
  logic [dht_pkg::SIZE_W-1:0]  stride;
  logic [dht_pkg::SIZE_W-1:0]  steps;
  dht_pkg::in_t                item;

  logic                        ram_we;
  logic [dht_pkg::ADDR_W-1:0]  ram_addr;
  logic [dht_pkg::WORD_W-1:0]  ram_wdata;
  logic [dht_pkg::WORD_W-1:0]  ram_rdata;

  dht_pkg::div_req_t           div_req;
  dht_pkg::div_rsp_t           div_rsp;

  logic                        rd_valid;
  logic [dht_pkg::KEY_W-1:0]   rd_key;
  logic [dht_pkg::VAL_W-1:0]   rd_val;
  logic                        hit;
  logic                        last_slot;
  logic [dht_pkg::SIZE_W-1:0]  cfg_size;
  logic [dht_pkg::SIZE_W:0]    probe_sum;
  logic [dht_pkg::ADDR_W-1:0]  probe_next;

  // Table word: {valid, key, value}
  assign rd_valid  = ram_rdata[dht_pkg::WORD_W-1];
  assign rd_key    = ram_rdata[dht_pkg::KEY_W+dht_pkg::VAL_W-1:dht_pkg::VAL_W];
  assign rd_val    = ram_rdata[dht_pkg::VAL_W-1:0];
  assign hit       = rd_valid && (rd_key == item.phone_key);
  assign last_slot = {1'b0, scan_idx} == n_size - 1'b1;

  // Size 0 behaves as 1, anything past the table depth as the depth
  always_comb begin
    cfg_size = cfg_wdata;
    if (cfg_wdata == '0) begin
      cfg_size = dht_pkg::SIZE_W'(1);
    end else if (cfg_wdata > dht_pkg::SIZE_MAX) begin
      cfg_size = dht_pkg::SIZE_MAX;
    end
  end

  // probe < n and stride <= n, so one conditional subtract wraps it
  always_comb begin
    probe_sum  = {2'b00, probe} + {1'b0, stride};
    probe_next = (probe_sum >= {1'b0, n_size})
               ? dht_pkg::ADDR_W'(probe_sum - {1'b0, n_size})
               : dht_pkg::ADDR_W'(probe_sum);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = scan_idx;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      S_SCAN_CK: begin
        ram_we = hit && (item.func == dht_pkg::FUNC_DELETE);
      end
      S_PROBE_RD: begin
        ram_addr = probe;
      end
      S_PROBE_CK: begin
        ram_addr  = probe;
        ram_we    = !rd_valid;
        ram_wdata = {1'b1, item.phone_key, item.caller_value};
      end
      default: begin
        ram_addr = scan_idx;
      end
    endcase
  end

  always_comb begin
    div_req.start    = (state == S_DIV1) || (state == S_DIV2);
    div_req.dividend = (state == S_DIV2) ? div_rsp.quotient : item.phone_key;
    div_req.divisor  = n_size;
  end

  assign in_ready = (state == S_IDLE) && !out_valid && !cfg_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      n_size      <= dht_pkg::SIZE_MAX;
      entry_count <= '0;
      clr_addr    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        n_size      <= cfg_size;
        entry_count <= '0;
        clr_addr    <= '0;
        state       <= S_CLEAR;
      end else begin
        case (state)
          S_CLEAR: begin
            clr_addr <= clr_addr + 1'b1;
            if (&clr_addr) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_valid && in_ready) begin
              item     <= in_data;
              scan_idx <= '0;
              if (in_data.func == dht_pkg::FUNC_INSERT ||
                  in_data.func == dht_pkg::FUNC_SEARCH ||
                  in_data.func == dht_pkg::FUNC_DELETE) begin
                state <= S_SCAN_RD;
              end else begin
                out_data  <= '{status: dht_pkg::ST_FAIL, slot: '0, found_value: '0};
                out_valid <= 1'b1;
              end
            end
          end
          S_SCAN_RD: begin
            state <= S_SCAN_CK;
          end
          S_SCAN_CK: begin
            if (hit) begin
              state     <= S_IDLE;
              out_valid <= 1'b1;
              if (item.func == dht_pkg::FUNC_SEARCH) begin
                out_data <= '{status: dht_pkg::ST_OK, slot: scan_idx, found_value: rd_val};
              end else if (item.func == dht_pkg::FUNC_DELETE) begin
                out_data <= '{status: dht_pkg::ST_OK, slot: scan_idx, found_value: '0};
                if (entry_count != '0) begin
                  entry_count <= entry_count - 1'b1;
                end
              end else begin
                // duplicate key: insert refused
                out_data <= '{status: dht_pkg::ST_FAIL, slot: '0, found_value: '0};
              end
            end else if (last_slot) begin
              if (item.func == dht_pkg::FUNC_INSERT && entry_count < n_size) begin
                state <= S_DIV1;
              end else begin
                state     <= S_IDLE;
                out_valid <= 1'b1;
                out_data  <= '{status: dht_pkg::ST_FAIL, slot: '0, found_value: '0};
              end
            end else begin
              scan_idx <= scan_idx + 1'b1;
              state    <= S_SCAN_RD;
            end
          end
          S_DIV1: begin
            state <= S_DIV1_W;
          end
          S_DIV1_W: begin
            if (div_rsp.done) begin
              probe <= div_rsp.remainder[dht_pkg::ADDR_W-1:0];
              state <= S_DIV2;
            end
          end
          S_DIV2: begin
            state <= S_DIV2_W;
          end
          S_DIV2_W: begin
            if (div_rsp.done) begin
              // even stride bumped to odd
              stride <= div_rsp.remainder[0] ? div_rsp.remainder
                                             : div_rsp.remainder + 1'b1;
              steps  <= '0;
              state  <= S_PROBE_RD;
            end
          end
          S_PROBE_RD: begin
            state <= S_PROBE_CK;
          end
          S_PROBE_CK: begin
            if (!rd_valid) begin
              entry_count <= entry_count + 1'b1;
              state       <= S_IDLE;
              out_valid   <= 1'b1;
              out_data    <= '{status: dht_pkg::ST_OK, slot: probe, found_value: '0};
            end else if (steps + 1'b1 == n_size) begin
              state     <= S_IDLE;
              out_valid <= 1'b1;
              out_data  <= '{status: dht_pkg::ST_FAIL, slot: '0, found_value: '0};
            end else begin
              steps <= steps + 1'b1;
              probe <= probe_next;
              state <= S_PROBE_RD;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  dht_ram #(
    .WIDTH (dht_pkg::WORD_W),
    .DEPTH (dht_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  dht_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // A taken beat always locks the input side for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= n_size)
    else $error("entry count exceeds table size");

  a_ready_out_free: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while result pending");

  a_div_idle_outside: assert property (@(posedge clk) disable iff (rst)
    div_rsp.busy |-> (state == S_DIV1_W || state == S_DIV2_W || cfg_we ||
                      state == S_CLEAR))
    else $error("divider running outside a divide step");

endmodule
